/* hdl/vtt_pkg.sv */
package vtt_pkg;

    // Grid geometry and widths.
    localparam int COLS      = 64;
    localparam int ROWS      = 24;
    localparam int MAX_ARGS  = 16;
    localparam int CELLS     = COLS * ROWS;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 5;
    localparam int ADDR_W    = 11;
    localparam int CNT_W     = 11;
    localparam int ARG_W     = 16;
    localparam int IDX_W     = 4;
    localparam int ARG_SLOTS = 16;
    localparam int ARG_MAX   = 65535;

    // Character codes.
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_NL   = 8'h0a;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] REV_BIT = 8'h80;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic [5:0]  read_col;
        logic [4:0]  read_row;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  cell_value;
        logic [5:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        reverse_on;
        logic        in_escape;
        logic        seq_error;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_BYTE,
        CMD_READ
    } t_cmd_kind;

    // Classified transaction handed from the front to the back.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [5:0]  col;
        logic [4:0]  row;
    } t_cmd;

endpackage

/* hdl/vt100_text_terminal_engine.sv */
// A plain byte passes from idle to the done state and then into the result register; a read
// also passes the read state first. Erase writes the cleared cells one at a time; scrolling reads
// and then writes each moved cell, then clears a line, repeated per scrolled line; one grid write port.
// Throughput: one transaction at a time in the back end; a two-entry queue takes input meanwhile until full.
// Reset is synchronous, active low; afterwards a sweep clears all 1536 grid cells
// and no transaction is taken until it ends.
module vt100_text_terminal_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vtt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vtt_pkg::t_out_item o_out_item
);
    import vtt_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Front end: accept and classify.
    vtt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: parser, grid and result register.
    vtt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

/* hdl/vtt_front.sv */
module vtt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  vtt_pkg::t_in_item i_in_item,
    output logic          o_cmd_valid,
    output vtt_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import vtt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       push;
    t_cmd       cls;

    // Classify the incoming transaction.
    always_comb begin
        cls.data = i_in_item.data_byte;
        cls.col  = i_in_item.read_col;
        cls.row  = i_in_item.read_row;
        if (i_in_item.opcode) begin
            cls.kind = CMD_READ;
        end else if (i_in_item.data_byte == 8'h00) begin
            cls.kind = CMD_NOP;
        end else begin
            cls.kind = CMD_BYTE;
        end
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Two-entry queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

/* hdl/vtt_back.sv */
module vtt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  vtt_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    output vtt_pkg::t_out_item o_out_item,
    input  logic          i_out_stall
);
    import vtt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SETUP, S_COPY, S_COPY_W,
        S_SKIP_RD, S_SKIP_CHK, S_RD, S_DONE
    } t_bstate;

    typedef enum logic [3:0] {
        P_GROUND, P_ESC, P_CHARSET, P_HASH, P_G0, P_G1,
        P_OSC, P_OSC_P, P_CSI, P_CSI_SKIP
    } t_pstate;

    typedef enum logic [2:0] {
        K_NONE, K_CLEAR, K_SUP, K_SDN, K_DCH
    } t_job;

    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row);
        row_base = ADDR_W'(row) * ADDR_W'(COLS);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = row_base(row) + ADDR_W'(col);
    endfunction

    logic [7:0]        r_mem [CELLS];
    logic [7:0]        r_rdata;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata;

    t_bstate           r_state, n_state;
    t_pstate           r_pst, n_pst;
    t_job              r_kind, n_kind;
    logic [ARG_W-1:0]  r_args [ARG_SLOTS];
    logic [ARG_W-1:0]  n_args [ARG_SLOTS];
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [2:0]        r_osc, n_osc;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row, r_top, n_top, r_bot, n_bot;
    logic              r_rev, n_rev;
    logic [ADDR_W-1:0] r_src, n_src, r_dst, n_dst, r_clr, n_clr;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_ccnt, n_ccnt;
    logic              r_desc, n_desc;
    logic [ROW_W-1:0]  r_rep, n_rep;
    logic              r_init, n_init;
    logic [7:0]        r_cell, n_cell;
    logic              r_cell_ok, n_cell_ok;
    logic              r_err, n_err;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_out, n_out;

    logic [ARG_W-1:0]  a0, a1, n, nm1, a1m1;
    logic [ARG_W:0]    sum_r, sum_c;
    logic [19:0]       prod;
    logic [6:0]        rem, ndc;
    logic [ADDR_W-1:0] here;
    logic [ROW_W-1:0]  lf_row;
    logic              lf_scroll;
    logic [7:0]        c;

    // Main sequencer: parses bytes, serves reads and walks the grid for erase, scroll and delete jobs.
    always_comb begin
        n_state = r_state;  n_pst = r_pst;  n_kind = r_kind;  n_args = r_args;
        n_idx = r_idx;  n_osc = r_osc;  n_col = r_col;  n_row = r_row;
        n_top = r_top;  n_bot = r_bot;  n_rev = r_rev;  n_src = r_src;
        n_dst = r_dst;  n_clr = r_clr;  n_cnt = r_cnt;  n_ccnt = r_ccnt;
        n_desc = r_desc;  n_rep = r_rep;  n_init = r_init;  n_cell = r_cell;
        n_cell_ok = r_cell_ok;  n_err = r_err;  n_ovalid = r_ovalid;  n_out = r_out;
        we = 1'b0;  waddr = r_clr;  wdata = 8'h00;  raddr = '0;  o_cmd_pop = 1'b0;

        c     = i_cmd.data;
        a0    = r_args[0];
        a1    = r_args[1];
        n     = (a0 != '0) ? a0 : ARG_W'(1);
        nm1   = n - ARG_W'(1);
        a1m1  = ((a1 != '0) ? a1 : ARG_W'(1)) - ARG_W'(1);
        sum_r = (ARG_W+1)'(r_row) + (ARG_W+1)'(n);
        sum_c = (ARG_W+1)'(r_col) + (ARG_W+1)'(n);
        prod  = 20'(r_args[r_idx]) * 20'd10 + 20'(c[3:0]);
        rem   = 7'(COLS) - 7'(r_col);
        ndc   = (n > ARG_W'(rem)) ? rem : n[6:0];
        here  = cell_addr(r_row, r_col);
        lf_scroll = (r_row == r_bot);
        lf_row    = (32'(r_row) < ROWS - 1) ? r_row + ROW_W'(1) : r_row;

        // The output register empties when its transaction is taken.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                if (r_ccnt == '0) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else if ((r_kind == K_SUP || r_kind == K_SDN) && r_rep > 1) begin
                        n_rep   = r_rep - ROW_W'(1);
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    we     = 1'b1;
                    waddr  = r_clr;
                    n_clr  = r_clr + ADDR_W'(1);
                    n_ccnt = r_ccnt - CNT_W'(1);
                end
            end
            S_SETUP: begin
                case (r_kind)
                    K_SUP: begin
                        n_dst   = row_base(r_top);
                        n_src   = row_base(r_top) + ADDR_W'(COLS);
                        n_cnt   = CNT_W'(r_bot - r_top) * CNT_W'(COLS);
                        n_desc  = 1'b0;
                        n_clr   = row_base(r_bot);
                        n_ccnt  = CNT_W'(COLS);
                        n_state = S_COPY;
                    end
                    K_SDN: begin
                        n_dst   = row_base(r_bot) + ADDR_W'(COLS - 1);
                        n_src   = row_base(r_bot) - ADDR_W'(1);
                        n_cnt   = CNT_W'(r_bot - r_top) * CNT_W'(COLS);
                        n_desc  = 1'b1;
                        n_clr   = row_base(r_top);
                        n_ccnt  = CNT_W'(COLS);
                        n_state = S_COPY;
                    end
                    default: begin
                        n_state = (r_cnt == '0) ? S_CLR : S_COPY;
                    end
                endcase
            end
            S_COPY: begin
                raddr   = r_src;
                n_state = S_COPY_W;
            end
            S_COPY_W: begin
                we    = 1'b1;
                waddr = r_dst;
                wdata = r_rdata;
                if (r_desc) begin
                    n_src = r_src - ADDR_W'(1);
                    n_dst = r_dst - ADDR_W'(1);
                end else begin
                    n_src = r_src + ADDR_W'(1);
                    n_dst = r_dst + ADDR_W'(1);
                end
                n_cnt   = r_cnt - CNT_W'(1);
                n_state = (r_cnt == CNT_W'(1)) ? S_CLR : S_COPY;
            end
            S_SKIP_RD: begin
                raddr   = here;
                n_state = S_SKIP_CHK;
            end
            S_SKIP_CHK: begin
                if (32'(r_col) < COLS - 1 && r_rdata != 8'h00) begin
                    n_col   = r_col + COL_W'(1);
                    n_state = S_SKIP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_cell  = r_cell_ok ? r_rdata : 8'h00;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.cell_value = r_cell;
                    n_out.cursor_col = r_col;
                    n_out.cursor_row = r_row;
                    n_out.reverse_on = r_rev;
                    n_out.in_escape  = (r_pst != P_GROUND);
                    n_out.seq_error  = r_err;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_err     = 1'b0;
                    n_cell    = 8'h00;
                    n_state   = S_DONE;
                    case (i_cmd.kind)
                        CMD_READ: begin
                            n_cell_ok = (32'(i_cmd.row) < ROWS);
                            raddr     = n_cell_ok ? cell_addr(i_cmd.row, i_cmd.col) : '0;
                            n_state   = S_RD;
                        end
                        CMD_BYTE: begin
                            if (r_pst == P_GROUND) begin
                                if (c == CH_ESC) begin
                                    n_pst = P_ESC;
                                    n_idx = '0;
                                    for (int k = 0; k < ARG_SLOTS; k++) begin
                                        n_args[k] = '0;
                                    end
                                end else if (c == CH_NL) begin
                                    n_col = '0;
                                    if (lf_scroll) begin
                                        n_kind  = K_SUP;
                                        n_rep   = ROW_W'(1);
                                        n_state = S_SETUP;
                                    end else begin
                                        n_row = lf_row;
                                    end
                                end else if (c == CH_BS) begin
                                    if (r_col != '0) begin
                                        n_col = r_col - COL_W'(1);
                                    end
                                end else begin
                                    // Printable or stored control byte.
                                    we    = 1'b1;
                                    waddr = here;
                                    wdata = r_rev ? (c | REV_BIT) : c;
                                    if (32'(r_col) == COLS - 1) begin
                                        n_col = '0;
                                        if (lf_scroll) begin
                                            n_kind  = K_SUP;
                                            n_rep   = ROW_W'(1);
                                            n_state = S_SETUP;
                                        end else begin
                                            n_row = lf_row;
                                        end
                                    end else begin
                                        n_col = r_col + COL_W'(1);
                                    end
                                end
                            end else begin
                                case (r_pst)
                                    P_ESC: begin
                                        case (c)
                                            "c", "D", "E", "M", "Z", "7", "8", ">", "=":
                                                n_pst = P_GROUND;
                                            "%": n_pst = P_CHARSET;
                                            "#": n_pst = P_HASH;
                                            "(": n_pst = P_G0;
                                            ")": n_pst = P_G1;
                                            "]": n_pst = P_OSC;
                                            "[": n_pst = P_CSI;
                                            default: n_pst = P_ESC;
                                        endcase
                                    end
                                    P_CHARSET: begin
                                        if (c == "@" || c == "G" || c == "8") begin
                                            n_pst = P_GROUND;
                                        end
                                    end
                                    P_HASH: begin
                                        if (c == "8") begin
                                            n_pst = P_GROUND;
                                        end
                                    end
                                    P_G0, P_G1: begin
                                        if (c == "B" || c == "0" || c == "U" || c == "K") begin
                                            n_pst = P_GROUND;
                                        end
                                    end
                                    P_OSC: begin
                                        if (c == "P") begin
                                            n_osc = '0;
                                            n_pst = P_OSC_P;
                                        end else if (c == "R" || c == CH_BEL) begin
                                            n_pst = P_GROUND;
                                        end
                                    end
                                    P_OSC_P: begin
                                        if (r_osc < 3'd6) begin
                                            n_osc = r_osc + 3'd1;
                                        end else begin
                                            n_pst = P_GROUND;
                                        end
                                    end
                                    P_CSI: begin
                                        n_pst = P_GROUND;
                                        if (c >= "0" && c <= "9") begin
                                            n_args[r_idx] = (prod > 20'(ARG_MAX)) ?
                                                            ARG_W'(ARG_MAX) : prod[ARG_W-1:0];
                                            n_pst = P_CSI;
                                        end else begin
                                            case (c)
                                                "[": n_pst = P_CSI_SKIP;
                                                "?": n_pst = P_CSI;
                                                ";": begin
                                                    if (32'(r_idx) < MAX_ARGS - 1) begin
                                                        n_idx = r_idx + IDX_W'(1);
                                                        n_args[n_idx] = '0;
                                                    end
                                                    n_pst = P_CSI;
                                                end
                                                "A": n_row = (n > ARG_W'(r_row)) ?
                                                             '0 : r_row - n[ROW_W-1:0];
                                                "B", "e": n_row = (32'(sum_r) > ROWS - 1) ?
                                                             ROW_W'(ROWS - 1) : sum_r[ROW_W-1:0];
                                                "C": n_col = (32'(sum_c) > COLS - 1) ?
                                                             COL_W'(COLS - 1) : sum_c[COL_W-1:0];
                                                "D": n_col = (n > ARG_W'(r_col)) ?
                                                             '0 : r_col - n[COL_W-1:0];
                                                "G": n_col = (32'(nm1) > COLS - 1) ?
                                                             COL_W'(COLS - 1) : nm1[COL_W-1:0];
                                                "d": n_row = (32'(nm1) > ROWS - 1) ?
                                                             ROW_W'(ROWS - 1) : nm1[ROW_W-1:0];
                                                "H": begin
                                                    n_row = (32'(nm1) > ROWS - 1) ?
                                                            ROW_W'(ROWS - 1) : nm1[ROW_W-1:0];
                                                    n_col = (32'(a1m1) > COLS - 1) ?
                                                            COL_W'(COLS - 1) : a1m1[COL_W-1:0];
                                                end
                                                "J": begin
                                                    if (a0 == 16'd0) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = here;
                                                        n_ccnt  = CNT_W'(CELLS) - CNT_W'(here);
                                                        n_state = S_CLR;
                                                    end else if (a0 == 16'd1) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = '0;
                                                        n_ccnt  = CNT_W'(here) + CNT_W'(1);
                                                        n_state = S_CLR;
                                                    end else if (a0 == 16'd2) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = '0;
                                                        n_ccnt  = CNT_W'(CELLS);
                                                        n_state = S_CLR;
                                                    end
                                                end
                                                "K": begin
                                                    if (a0 == 16'd0) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = here;
                                                        n_ccnt  = CNT_W'(rem);
                                                        n_state = S_CLR;
                                                    end else if (a0 == 16'd1) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = row_base(r_row);
                                                        n_ccnt  = CNT_W'(r_col) + CNT_W'(1);
                                                        n_state = S_CLR;
                                                    end else if (a0 == 16'd2) begin
                                                        n_kind  = K_CLEAR;
                                                        n_clr   = row_base(r_row);
                                                        n_ccnt  = CNT_W'(COLS);
                                                        n_state = S_CLR;
                                                    end
                                                end
                                                "P": begin
                                                    n_kind  = K_DCH;
                                                    n_dst   = here;
                                                    n_src   = here + ADDR_W'(ndc);
                                                    n_cnt   = CNT_W'(rem - ndc);
                                                    n_desc  = 1'b0;
                                                    n_clr   = here + ADDR_W'(rem) - ADDR_W'(ndc);
                                                    n_ccnt  = CNT_W'(ndc);
                                                    n_state = S_SETUP;
                                                end
                                                "S", "T": begin
                                                    n_kind  = (c == "S") ? K_SUP : K_SDN;
                                                    n_rep   = (32'(n) > ROWS) ?
                                                              ROW_W'(ROWS) : n[ROW_W-1:0];
                                                    n_state = S_SETUP;
                                                end
                                                "h", "l": n_pst = P_GROUND;
                                                "m": begin
                                                    if (a0 == 16'd7 || a0 == 16'd44) begin
                                                        n_rev = 1'b1;
                                                    end else if (a0 == 16'd0 || a0 == 16'd27 ||
                                                                 a0 == 16'd40) begin
                                                        n_rev = 1'b0;
                                                    end
                                                end
                                                "r": begin
                                                    if (nm1 < ((a1 == '0 || 32'(a1) > ROWS) ?
                                                               ARG_W'(ROWS - 1) : a1m1)) begin
                                                        n_top = nm1[ROW_W-1:0];
                                                        n_bot = (a1 == '0 || 32'(a1) > ROWS) ?
                                                                ROW_W'(ROWS - 1) : a1m1[ROW_W-1:0];
                                                    end
                                                end
                                                ">": n_state = S_SKIP_RD;
                                                default: n_err = 1'b1;
                                            endcase
                                        end
                                    end
                                    default: n_pst = P_GROUND;
                                endcase
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state; reset starts the clearing sweep of the grid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_ccnt   <= CNT_W'(CELLS);
            r_kind   <= K_NONE;
            r_pst    <= P_GROUND;
            r_idx    <= '0;
            r_osc    <= '0;
            r_col    <= COL_W'(1);
            r_row    <= '0;
            r_top    <= '0;
            r_bot    <= ROW_W'(ROWS - 1);
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
            r_rep    <= '0;
            r_cnt    <= '0;
            for (int k = 0; k < ARG_SLOTS; k++) begin
                r_args[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_clr    <= n_clr;
            r_ccnt   <= n_ccnt;
            r_kind   <= n_kind;
            r_pst    <= n_pst;
            r_idx    <= n_idx;
            r_osc    <= n_osc;
            r_col    <= n_col;
            r_row    <= n_row;
            r_top    <= n_top;
            r_bot    <= n_bot;
            r_rev    <= n_rev;
            r_ovalid <= n_ovalid;
            r_rep    <= n_rep;
            r_cnt    <= n_cnt;
            r_args   <= n_args;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_desc    <= n_desc;
        r_cell    <= n_cell;
        r_cell_ok <= n_cell_ok;
        r_err     <= n_err;
        r_out     <= n_out;
    end

    // Character grid memory, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS) else $error("cursor row outside the grid");
    a_region_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < r_bot) else $error("scroll region top not above bottom");
    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_cmd_pop) else $error("transaction taken during reset sweep");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state != S_IDLE) else $error("sequencer did not leave idle");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vtt_pkg::*;

    // Parser states of the terminal model.
    typedef enum int {
        PS_GROUND, PS_ESC, PS_CHARSET, PS_HASH, PS_G0, PS_G1,
        PS_OSC, PS_OSC_P, PS_CSI, PS_CSI_SKIP
    } t_parse;

    // Opcodes of an input transaction.
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // CSI final bytes and other sequence codes.
    localparam logic [7:0] CSI_UP     = "A";
    localparam logic [7:0] CSI_DOWN   = "B";
    localparam logic [7:0] CSI_RIGHT  = "C";
    localparam logic [7:0] CSI_LEFT   = "D";
    localparam logic [7:0] CSI_COLABS = "G";
    localparam logic [7:0] CSI_ROWABS = "d";
    localparam logic [7:0] CSI_ROWREL = "e";
    localparam logic [7:0] CSI_POS    = "H";
    localparam logic [7:0] CSI_ED     = "J";
    localparam logic [7:0] CSI_EL     = "K";
    localparam logic [7:0] CSI_DCH    = "P";
    localparam logic [7:0] CSI_SU     = "S";
    localparam logic [7:0] CSI_SD     = "T";
    localparam logic [7:0] CSI_SET    = "h";
    localparam logic [7:0] CSI_RESET  = "l";
    localparam logic [7:0] CSI_SGR    = "m";
    localparam logic [7:0] CSI_REGION = "r";
    localparam logic [7:0] CSI_SKIPNZ = ">";
    localparam logic [7:0] CSI_PRIV   = "?";
    localparam logic [7:0] CSI_SEP    = ";";
    localparam logic [7:0] CSI_OPEN   = "[";
    localparam logic [7:0] CSI_BAD    = "z";
    localparam logic [7:0] ESC_OSC    = "]";
    localparam logic [7:0] ESC_CHSET  = "%";
    localparam logic [7:0] ESC_HASH   = "#";
    localparam logic [7:0] ESC_G0     = "(";
    localparam logic [7:0] ESC_G1     = ")";
    localparam logic [7:0] OSC_PAL    = "P";
    localparam logic [7:0] OSC_RST    = "R";

    localparam int HOLD_CYCLES = 3000;
    localparam int RAND_ITEMS  = 600;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    vt100_text_terminal_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Terminal state mirrored by the predictor.
    logic [7:0] grid [CELLS];
    int         cur_col, cur_row, reg_top, reg_bot, rev_flag, osc_cnt, arg_idx;
    int         args [ARG_SLOTS];
    t_parse     pstate;

    t_out_item  expected_q [$];
    t_in_item   byte_q [$];
    int         err_cnt = 0;
    bit         quiet = 0;
    bit         hold_req = 0;
    bit         hold_done = 0;

    function automatic int clamp_to(int v, int hi);
        return v > hi ? hi : v;
    endfunction

    function automatic void clear_span(int from, int to);
        if (to > CELLS) to = CELLS;
        for (int i = from; i < to; i++) grid[i] = '0;
    endfunction

    function automatic void copy_row(int dst, int src);
        for (int c = 0; c < COLS; c++) grid[dst * COLS + c] = grid[src * COLS + c];
    endfunction

    function automatic void scroll_up();
        for (int r = reg_top; r < reg_bot; r++) copy_row(r, r + 1);
        clear_span(reg_bot * COLS, (reg_bot + 1) * COLS);
    endfunction

    function automatic void scroll_down();
        for (int r = reg_bot; r > reg_top; r--) copy_row(r, r - 1);
        clear_span(reg_top * COLS, (reg_top + 1) * COLS);
    endfunction

    function automatic void line_feed();
        if (cur_row == reg_bot) scroll_up();
        else if (cur_row < ROWS - 1) cur_row++;
    endfunction

    function automatic void clear_args();
        foreach (args[i]) args[i] = 0;
        arg_idx = 0;
    endfunction

    function automatic void terminal_reset();
        foreach (grid[i]) grid[i] = '0;
        cur_col = 1;
        cur_row = 0;
        reg_top = 0;
        reg_bot = ROWS - 1;
        rev_flag = 0;
        osc_cnt = 0;
        pstate = PS_GROUND;
        clear_args();
    endfunction

    // One byte inside a control sequence; returns 1 on an unknown final byte.
    function automatic bit csi_apply(int c);
        int a0, a1, n, here, top, bot;
        a0 = args[0];
        a1 = args[1];
        n = a0 != 0 ? a0 : 1;
        here = cur_row * COLS + cur_col;
        pstate = PS_GROUND;
        if (c >= "0" && c <= "9") begin
            args[arg_idx % ARG_SLOTS] = clamp_to(args[arg_idx % ARG_SLOTS] * 10 + c - "0",
                                                 ARG_MAX);
            pstate = PS_CSI;
            return 0;
        end
        case (c)
            CSI_OPEN: pstate = PS_CSI_SKIP;
            CSI_PRIV: pstate = PS_CSI;
            CSI_SEP: begin
                if (arg_idx < MAX_ARGS - 1) begin
                    arg_idx++;
                    args[arg_idx % ARG_SLOTS] = 0;
                end
                pstate = PS_CSI;
            end
            CSI_UP:     cur_row = n > cur_row ? 0 : cur_row - n;
            CSI_DOWN:   cur_row = clamp_to(cur_row + n, ROWS - 1);
            CSI_RIGHT:  cur_col = clamp_to(cur_col + n, COLS - 1);
            CSI_LEFT:   cur_col = n > cur_col ? 0 : cur_col - n;
            CSI_COLABS: cur_col = clamp_to(n - 1, COLS - 1);
            CSI_ROWABS: cur_row = clamp_to(n - 1, ROWS - 1);
            CSI_ROWREL: cur_row = clamp_to(cur_row + n, ROWS - 1);
            CSI_POS: begin
                cur_row = clamp_to(n - 1, ROWS - 1);
                cur_col = clamp_to((a1 != 0 ? a1 : 1) - 1, COLS - 1);
            end
            CSI_ED: begin
                if (a0 == 0) clear_span(here, CELLS);
                else if (a0 == 1) clear_span(0, here + 1);
                else if (a0 == 2) clear_span(0, CELLS);
            end
            CSI_EL: begin
                if (a0 == 0) clear_span(here, (cur_row + 1) * COLS);
                else if (a0 == 1) clear_span(cur_row * COLS, here + 1);
                else if (a0 == 2) clear_span(cur_row * COLS, (cur_row + 1) * COLS);
            end
            CSI_DCH: begin
                n = clamp_to(n, COLS - cur_col);
                for (int i = 0; i < COLS - cur_col - n; i++) grid[here + i] = grid[here + n + i];
                clear_span((cur_row + 1) * COLS - n, (cur_row + 1) * COLS);
            end
            CSI_SU: begin
                n = clamp_to(n, ROWS);
                for (int i = 0; i < n; i++) scroll_up();
            end
            CSI_SD: begin
                n = clamp_to(n, ROWS);
                for (int i = 0; i < n; i++) scroll_down();
            end
            CSI_SET, CSI_RESET: ;
            CSI_SGR: begin
                if (a0 == 7 || a0 == 44) rev_flag = 1;
                else if (a0 == 0 || a0 == 27 || a0 == 40) rev_flag = 0;
            end
            CSI_REGION: begin
                top = (a0 != 0 ? a0 : 1) - 1;
                bot = (a1 == 0 || a1 > ROWS) ? ROWS - 1 : a1 - 1;
                if (top < bot) begin
                    reg_top = top;
                    reg_bot = bot;
                end
            end
            CSI_SKIPNZ: begin
                while (cur_col < COLS - 1 && grid[cur_row * COLS + cur_col] != 0) cur_col++;
            end
            default: return 1;
        endcase
        return 0;
    endfunction

    function automatic bit escape_apply(int c);
        case (pstate)
            PS_ESC: begin
                case (c)
                    "c", "D", "E", "M", "Z", "7", "8", ">", "=": pstate = PS_GROUND;
                    ESC_CHSET: pstate = PS_CHARSET;
                    ESC_HASH:  pstate = PS_HASH;
                    ESC_G0:    pstate = PS_G0;
                    ESC_G1:    pstate = PS_G1;
                    ESC_OSC:   pstate = PS_OSC;
                    CSI_OPEN:  pstate = PS_CSI;
                    default: ;
                endcase
            end
            PS_CHARSET: if (c == "@" || c == "G" || c == "8") pstate = PS_GROUND;
            PS_HASH: if (c == "8") pstate = PS_GROUND;
            PS_G0, PS_G1: if (c == "B" || c == "0" || c == "U" || c == "K") pstate = PS_GROUND;
            PS_OSC: begin
                if (c == OSC_PAL) begin
                    osc_cnt = 0;
                    pstate = PS_OSC_P;
                end else if (c == OSC_RST || c == CH_BEL) begin
                    pstate = PS_GROUND;
                end
            end
            PS_OSC_P: begin
                if (osc_cnt < 6) osc_cnt++;
                else pstate = PS_GROUND;
            end
            PS_CSI: return csi_apply(c);
            default: pstate = PS_GROUND;
        endcase
        return 0;
    endfunction

    // Advances the terminal by one transaction and returns its result.
    function automatic t_out_item terminal_step(t_in_item it);
        t_out_item r;
        int c;
        r = '0;
        c = it.data_byte;
        if (it.opcode == OP_READ) begin
            if (it.read_col < COLS && it.read_row < ROWS)
                r.cell_value = grid[it.read_row * COLS + it.read_col];
        end else if (c != 0) begin
            if (pstate != PS_GROUND) begin
                r.seq_error = escape_apply(c);
            end else if (c == CH_ESC) begin
                pstate = PS_ESC;
                clear_args();
            end else if (c == CH_NL) begin
                cur_col = 0;
                line_feed();
            end else if (c == CH_BS) begin
                if (cur_col > 0) cur_col--;
            end else begin
                grid[cur_row * COLS + cur_col] = rev_flag != 0 ? (c | REV_BIT) : c;
                cur_col++;
                if (cur_col > COLS - 1) begin
                    cur_col = 0;
                    line_feed();
                end
            end
        end
        r.cursor_col = cur_col;
        r.cursor_row = cur_row;
        r.reverse_on = rev_flag[0];
        r.in_escape  = pstate != PS_GROUND;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // Offers one transaction and records its expected result once accepted.
    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item res;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        res = terminal_step(it);
        expected_q.push_back(typed ? typed_res : res);
    endtask

    // Result side: random stall bursts, one long hold-off, field checks.
    initial begin
        int stall_left;
        t_out_item want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (out_item.cell_value !== want.cell_value)
                        report_mismatch("cell_value", out_item.cell_value, want.cell_value);
                    if (out_item.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", out_item.cursor_col, want.cursor_col);
                    if (out_item.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", out_item.cursor_row, want.cursor_row);
                    if (out_item.reverse_on !== want.reverse_on)
                        report_mismatch("reverse_on", out_item.reverse_on, want.reverse_on);
                    if (out_item.in_escape !== want.in_escape)
                        report_mismatch("in_escape", out_item.in_escape, want.in_escape);
                    if (out_item.seq_error !== want.seq_error)
                        report_mismatch("seq_error", out_item.seq_error, want.seq_error);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic void push_byte(logic [7:0] b);
        t_in_item it;
        it.opcode = OP_FEED;
        it.data_byte = b;
        it.read_col = $urandom;
        it.read_row = $urandom;
        byte_q.push_back(it);
    endfunction

    function automatic void push_num(int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    // Builds one control sequence with random arguments.
    function automatic void gen_csi();
        logic [7:0] finals [19];
        logic [7:0] fin;
        int nargs, v;
        finals = '{CSI_UP, CSI_DOWN, CSI_RIGHT, CSI_LEFT, CSI_COLABS, CSI_ROWABS,
                   CSI_ROWREL, CSI_POS, CSI_ED, CSI_EL, CSI_DCH, CSI_SU, CSI_SD,
                   CSI_SET, CSI_RESET, CSI_SGR, CSI_REGION, CSI_SKIPNZ, CSI_BAD};
        fin = finals[$urandom_range(0, 18)];
        if ($urandom_range(0, 15) == 0) fin = $urandom_range(1, 255);
        push_byte(CH_ESC);
        push_byte(CSI_OPEN);
        if ($urandom_range(0, 9) == 0) push_byte(CSI_PRIV);
        if ($urandom_range(0, 19) == 0) push_byte(CSI_OPEN);
        nargs = $urandom_range(0, 3);
        if ($urandom_range(0, 29) == 0) nargs = 18;
        for (int i = 0; i < nargs; i++) begin
            if (i > 0) push_byte(CSI_SEP);
            case ($urandom_range(0, 9))
                0: v = -1;
                1: v = 99999;
                2: v = $urandom_range(0, 1000);
                default: v = $urandom_range(0, 30);
            endcase
            if ((fin == CSI_SU || fin == CSI_SD) && i == 0) v = $urandom_range(0, 4);
            if (fin == CSI_SGR && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0: v = 7;
                    1: v = 44;
                    2: v = 0;
                    3: v = 27;
                    default: v = 40;
                endcase
            end
            if (v >= 0) push_num(v);
        end
        push_byte(fin);
    endfunction

    function automatic void gen_sequence();
        t_in_item it;
        int k;
        logic [7:0] esc1 [9];
        esc1 = '{"c", "D", "E", "M", "Z", "7", "8", ">", "="};
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                k = $urandom_range(1, 20);
                repeat (k) push_byte($urandom_range(0, 7) == 0 ? $urandom_range(1, 255)
                                                                 : $urandom_range(32, 126));
            end
            4: push_byte(CH_NL);
            5: push_byte(CH_BS);
            6, 7, 8, 9, 10, 11: gen_csi();
            12: begin
                push_byte(CH_ESC);
                push_byte(esc1[$urandom_range(0, 8)]);
            end
            13: begin
                push_byte(CH_ESC);
                case ($urandom_range(0, 3))
                    0: begin push_byte(ESC_CHSET); push_byte("G"); end
                    1: begin push_byte(ESC_HASH); push_byte("8"); end
                    2: begin push_byte(ESC_G0); push_byte("B"); end
                    default: begin push_byte(ESC_G1); push_byte("0"); end
                endcase
            end
            14: begin
                push_byte(CH_ESC);
                push_byte(ESC_OSC);
                case ($urandom_range(0, 2))
                    0: begin
                        push_byte(OSC_PAL);
                        repeat (7) push_byte($urandom_range(1, 255));
                    end
                    1: push_byte(OSC_RST);
                    default: push_byte(CH_BEL);
                endcase
            end
            15, 16, 17: begin
                it.opcode = OP_READ;
                it.data_byte = $urandom;
                it.read_col = $urandom;
                it.read_row = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                         : $urandom_range(0, ROWS - 1);
                byte_q.push_back(it);
            end
            default: begin
                it = $urandom;
                byte_q.push_back(it);
            end
        endcase
    endfunction

    typedef struct packed {
        logic      typed;
        t_in_item  item;
        t_out_item res;
    } t_dir_row;

    function automatic t_in_item mk_feed(logic [7:0] b);
        return '{OP_FEED, b, 6'd0, 5'd0};
    endfunction

    function automatic t_in_item mk_read(int col, int row);
        return '{OP_READ, 8'd0, col[5:0], row[4:0]};
    endfunction

    // Directed part: reset contents, extremes, controls, reverse video, errors, erase.
    t_dir_row dir_rows [24];

    initial begin
        int sent;
        t_in_item it;
        dir_rows = '{
            '{1'b1, mk_read(0, 0),   '{8'd0, 6'd1, 5'd0, 1'b0, 1'b0, 1'b0}},
            '{1'b1, mk_read(63, 23), '{8'd0, 6'd1, 5'd0, 1'b0, 1'b0, 1'b0}},
            '{1'b1, mk_read(63, 31), '{8'd0, 6'd1, 5'd0, 1'b0, 1'b0, 1'b0}},
            '{1'b1, mk_feed(8'h00),  '{8'd0, 6'd1, 5'd0, 1'b0, 1'b0, 1'b0}},
            '{1'b0, mk_feed(8'hff),  '0},
            '{1'b0, mk_feed("A"),    '0},
            '{1'b0, mk_feed(CH_BS),  '0},
            '{1'b0, mk_feed(CH_BS),  '0},
            '{1'b0, mk_feed(CH_BS),  '0},
            '{1'b0, mk_feed(CH_NL),  '0},
            '{1'b0, mk_feed(CH_ESC), '0},
            '{1'b0, mk_feed(CSI_OPEN), '0},
            '{1'b0, mk_feed("7"),    '0},
            '{1'b0, mk_feed(CSI_SGR), '0},
            '{1'b0, mk_feed("q"),    '0},
            '{1'b0, mk_read(0, 1),   '0},
            '{1'b0, mk_feed(CH_ESC), '0},
            '{1'b0, mk_feed(CSI_OPEN), '0},
            '{1'b0, mk_feed(CSI_BAD), '0},
            '{1'b0, mk_feed(CH_ESC), '0},
            '{1'b0, mk_feed(CSI_OPEN), '0},
            '{1'b0, mk_feed("2"),    '0},
            '{1'b0, mk_feed(CSI_ED), '0},
            '{1'b0, mk_read(1, 0),   '0}
        };
        terminal_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

        // Random part: mostly well-formed sequences, some noise.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            gen_sequence();
            while (byte_q.size() > 0) begin
                it = byte_q.pop_front();
                send_item(it, 1'b0, '0);
                if (it.opcode == OP_READ || it.data_byte != 0) sent++;
                if (sent == 150) hold_req = 1;
                if (sent >= RAND_ITEMS - 100) quiet = 1;
            end
        end
        in_valid <= 1'b0;

        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1000ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* vt100_text_terminal_engine.f */
hdl/vtt_pkg.sv
hdl/vtt_front.sv
hdl/vtt_back.sv
hdl/vt100_text_terminal_engine.sv
tb/tb_top.sv
